FILE: hw/rtl/spcc_pkg.sv
// ----------------------------------------------------------------------------
// spcc_pkg
// Shared types, code table and lookup functions of the static prefix code
// codec.
// ----------------------------------------------------------------------------
package spcc_pkg;

   localparam int SYMBOL_COUNT       = 29;
   localparam int CODE_W             = 9;   // longest code in bits
   localparam int LEN_W              = 4;   // holds a code length 0..9
   localparam int BYTE_W             = 8;
   localparam int QUEUE_DEPTH_DEFAULT = 2;

   // code table, searched in this order (first hit wins)
   localparam logic [BYTE_W-1:0] CODE_SYM [SYMBOL_COUNT] = '{
      8'h61, 8'h62, 8'h63, 8'h64, 8'h65, 8'h66, 8'h67, 8'h68, 8'h69, 8'h6A,
      8'h6B, 8'h6C, 8'h6D, 8'h6E, 8'h6F, 8'h70, 8'h71, 8'h72, 8'h73, 8'h74,
      8'h75, 8'h76, 8'h77, 8'h78, 8'h79, 8'h7A, 8'h0A, 8'h2E, 8'h20
   };

   localparam logic [CODE_W-1:0] CODE_BITS [SYMBOL_COUNT] = '{
      9'h00E, 9'h047, 9'h017, 9'h087, 9'h009, 9'h044, 9'h046, 9'h045,
      9'h00C, 9'h03E, 9'h003, 9'h041, 9'h040, 9'h005, 9'h00A, 9'h002,
      9'h109, 9'h004, 9'h01B, 9'h01A, 9'h03F, 9'h108, 9'h01E, 9'h085,
      9'h016, 9'h002, 9'h003, 9'h006, 9'h007
   };

   localparam logic [LEN_W-1:0] CODE_LEN [SYMBOL_COUNT] = '{
      4'd4, 4'd7, 4'd5, 4'd8, 4'd4, 4'd7, 4'd7, 4'd7, 4'd4, 4'd6,
      4'd5, 4'd7, 4'd7, 4'd4, 4'd4, 4'd5, 4'd9, 4'd4, 4'd5, 4'd5,
      4'd6, 4'd9, 4'd5, 4'd8, 4'd5, 4'd4, 4'd4, 4'd4, 4'd4
   };

   // one queued item: bits to shift, left aligned, and how many of them
   typedef struct packed {
      logic              decode;
      logic              eos;
      logic [CODE_W-1:0] bits;
      logic [LEN_W-1:0]  nbits;
   } entry_type;

   typedef struct packed {
      logic              found;
      logic [CODE_W-1:0] code;
      logic [LEN_W-1:0]  len;
   } enc_lookup_type;

   typedef struct packed {
      logic              found;
      logic [BYTE_W-1:0] sym;
   } dec_match_type;

   // character to code
   function automatic enc_lookup_type encode_lookup(input logic [BYTE_W-1:0] ch);
      enc_lookup_type res;
      res = '0;
      for (int k = 0; k < SYMBOL_COUNT; k++) begin
         if (!res.found && CODE_SYM[k] == ch) begin
            res.found = 1'b1;
            res.code  = CODE_BITS[k];
            res.len   = CODE_LEN[k];
         end
      end
      return res;
   endfunction

   // pending code and its length to symbol
   function automatic dec_match_type decode_match(input logic [CODE_W-1:0] code,
                                                   input logic [LEN_W-1:0] len);
      dec_match_type res;
      res = '0;
      for (int k = 0; k < SYMBOL_COUNT; k++) begin
         if (!res.found && CODE_LEN[k] == len && CODE_BITS[k] == code) begin
            res.found = 1'b1;
            res.sym   = CODE_SYM[k];
         end
      end
      return res;
   endfunction

endpackage

FILE: hw/rtl/static_prefix_code_codec_unit.sv
// ----------------------------------------------------------------------------
// static_prefix_code_codec_unit
// Static prefix code codec over a 29-symbol alphabet, encode or decode.
// Each item is popped by the back unit, its bits shifted through the bit
//   accumulator, then its results handed out before the next item is taken.
// Throughput: one bit per cycle in the back unit's shift loop.
// Reset (synchronous): encode mode, queue empty, bit accumulator cleared.
// ----------------------------------------------------------------------------
module static_prefix_code_codec_unit
   import spcc_pkg::*;
#(
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
)
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [BYTE_W-1:0] req_tdata,   // [7:0] in_byte
   input  logic              req_tlast,   // end_of_stream
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [BYTE_W-1:0] rsp_tdata,   // [7:0] out_byte
   output logic              rsp_tlast,   // last_of_run
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic              csr_wdata    // mode_select
);

   logic      mode_ff, mode_in;
   logic      csr_write;
   logic      push, pop, queue_full, queue_empty;
   entry_type push_entry, pop_entry;

   // mode register, a write also clears the bit state
   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;
   assign mode_in   = csr_write ? csr_wdata : mode_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= 1'b0;
      end else begin
         mode_ff <= mode_in;
      end
   end

   spcc_front u_front (
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tlast   (req_tlast),
      .decode_mode (mode_ff),
      .queue_full  (queue_full),
      .push        (push),
      .push_entry  (push_entry)
   );

   spcc_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .full       (queue_full),
      .pop        (pop),
      .pop_entry  (pop_entry),
      .empty      (queue_empty)
   );

   spcc_back u_back (
      .clock       (clock),
      .reset       (reset),
      .clear       (csr_write),
      .queue_empty (queue_empty),
      .queue_entry (pop_entry),
      .pop         (pop),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast)
   );

endmodule

FILE: hw/rtl/spcc_front.sv
// ----------------------------------------------------------------------------
// spcc_front
// Accepts input transfers and classifies them into queue entries: a code
// lookup for encoding, the raw byte for decoding.
// ----------------------------------------------------------------------------
module spcc_front
   import spcc_pkg::*;
(
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [BYTE_W-1:0] req_tdata,   // [7:0] in_byte
   input  logic              req_tlast,   // end_of_stream
   input  logic              decode_mode,
   input  logic              queue_full,
   output logic              push,
   output entry_type         push_entry
);

   enc_lookup_type lookup;

   // take a transfer whenever the queue has room
   assign req_tready = !queue_full;
   assign push       = req_tvalid && req_tready;

   // symbol lookup, unknown bytes give zero bits
   always_comb begin
      lookup = encode_lookup(req_tdata);
   end

   // build the entry with its bits left aligned
   always_comb begin
      push_entry.decode = decode_mode;
      push_entry.eos    = req_tlast;
      if (decode_mode) begin
         push_entry.bits  = {req_tdata, {(CODE_W-BYTE_W){1'b0}}};
         push_entry.nbits = LEN_W'(BYTE_W);
      end else if (lookup.found) begin
         push_entry.bits  = CODE_W'(lookup.code << (LEN_W'(CODE_W) - lookup.len));
         push_entry.nbits = lookup.len;
      end else begin
         push_entry.bits  = '0;
         push_entry.nbits = '0;
      end
   end

endmodule

FILE: hw/rtl/spcc_queue.sv
// ----------------------------------------------------------------------------
// spcc_queue
// Short first-in first-out queue of classified items between the front and
// the back unit.
// ----------------------------------------------------------------------------
module spcc_queue
   import spcc_pkg::*;
#(
   parameter int DEPTH = QUEUE_DEPTH_DEFAULT
)
(
   input  logic      clock,
   input  logic      reset,
   input  logic      push,
   input  entry_type push_entry,
   output logic      full,
   input  logic      pop,
   output entry_type pop_entry,
   output logic      empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

   entry_type        slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign full      = (count_ff == CNT_W'(DEPTH));
   assign empty     = (count_ff == '0);
   assign pop_entry = slot_ff[rd_ptr_ff];

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

   // fill count never passes the depth
   assert property (@(posedge clock) disable iff (reset) count_ff <= CNT_W'(DEPTH))
      else $error("queue count beyond depth");

endmodule

FILE: hw/rtl/spcc_back.sv
// ----------------------------------------------------------------------------
// spcc_back
// Back unit: shifts the bits of one queued item one per cycle through the
// bit accumulator, packs or matches codes, then hands the item's results out.
// ----------------------------------------------------------------------------
module spcc_back
   import spcc_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              clear,
   input  logic              queue_empty,
   input  entry_type         queue_entry,
   output logic              pop,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [BYTE_W-1:0] rsp_tdata,   // [7:0] out_byte
   output logic              rsp_tlast    // last_of_run
);

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_SHIFT  = 2'd1;
   localparam logic [1:0] ST_FINISH = 2'd2;
   localparam logic [1:0] ST_DRAIN  = 2'd3;

   logic [1:0]        state_ff, state_in;
   logic [CODE_W-1:0] bits_ff, bits_in;
   logic [LEN_W-1:0]  rem_ff, rem_in;
   logic              decode_ff, decode_in;
   logic              eos_ff, eos_in;
   logic [CODE_W-1:0] acc_ff, acc_in;
   logic [LEN_W-1:0]  cnt_ff, cnt_in;
   logic [BYTE_W-1:0] res_ff [2];
   logic [1:0]        res_n_ff, res_n_in;
   logic              rd_idx_ff, rd_idx_in;

   logic              emit;
   logic [BYTE_W-1:0] emit_byte;
   logic [CODE_W-1:0] acc_shift;
   logic [LEN_W-1:0]  cnt_inc;
   dec_match_type     match;
   logic              drain_last;

   assign acc_shift = {acc_ff[CODE_W-2:0], bits_ff[CODE_W-1]};
   assign cnt_inc   = cnt_ff + 1'b1;
   assign pop       = (state_ff == ST_IDLE) && !queue_empty;

   always_comb begin
      match = decode_match(acc_shift, cnt_inc);
   end

   // output side reads the result buffer
   assign rsp_tvalid = (state_ff == ST_DRAIN);
   assign rsp_tdata  = res_ff[rd_idx_ff];
   assign drain_last = ({1'b0, rd_idx_ff} == res_n_ff - 2'd1);
   assign rsp_tlast  = drain_last;

   // sequencer and bit accumulator
   always_comb begin
      state_in  = state_ff;
      bits_in   = bits_ff;
      rem_in    = rem_ff;
      decode_in = decode_ff;
      eos_in    = eos_ff;
      acc_in    = acc_ff;
      cnt_in    = cnt_ff;
      res_n_in  = res_n_ff;
      rd_idx_in = rd_idx_ff;
      emit      = 1'b0;
      emit_byte = '0;
      case (state_ff)
         ST_IDLE: begin
            if (pop) begin
               bits_in   = queue_entry.bits;
               rem_in    = queue_entry.nbits;
               decode_in = queue_entry.decode;
               eos_in    = queue_entry.eos;
               res_n_in  = '0;
               rd_idx_in = 1'b0;
               state_in  = (queue_entry.nbits == '0) ? ST_FINISH : ST_SHIFT;
            end
         end
         ST_SHIFT: begin
            bits_in = bits_ff << 1;
            rem_in  = rem_ff - 1'b1;
            if (decode_ff) begin
               // extend the pending code and try the table
               if (match.found) begin
                  emit      = 1'b1;
                  emit_byte = match.sym;
                  acc_in    = '0;
                  cnt_in    = '0;
               end else if (cnt_inc == LEN_W'(CODE_W)) begin
                  acc_in = '0;
                  cnt_in = '0;
               end else begin
                  acc_in = acc_shift;
                  cnt_in = cnt_inc;
               end
            end else begin
               // queue one code bit, a full byte leaves
               if (cnt_inc == LEN_W'(BYTE_W)) begin
                  emit      = 1'b1;
                  emit_byte = acc_shift[BYTE_W-1:0];
                  acc_in    = '0;
                  cnt_in    = '0;
               end else begin
                  acc_in = acc_shift;
                  cnt_in = cnt_inc;
               end
            end
            if (rem_ff == LEN_W'(1)) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            // end of stream: flush a padded byte or drop pending bits
            if (eos_ff) begin
               if (!decode_ff && cnt_ff != '0) begin
                  emit      = 1'b1;
                  emit_byte = BYTE_W'(acc_ff[BYTE_W-1:0] << (LEN_W'(BYTE_W) - cnt_ff));
               end
               acc_in = '0;
               cnt_in = '0;
            end
            rd_idx_in = 1'b0;
            state_in  = (res_n_ff != '0 || emit) ? ST_DRAIN : ST_IDLE;
         end
         ST_DRAIN: begin
            if (rsp_tready) begin
               if (drain_last) begin
                  state_in = ST_IDLE;
               end else begin
                  rd_idx_in = 1'b1;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      if (emit && res_n_ff != 2'd2) begin
         res_n_in = res_n_ff + 1'b1;
      end
      if (clear) begin
         acc_in = '0;
         cnt_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         acc_ff   <= '0;
         cnt_ff   <= '0;
         res_n_ff <= '0;
         rd_idx_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         acc_ff   <= acc_in;
         cnt_ff   <= cnt_in;
         res_n_ff <= res_n_in;
         rd_idx_ff <= rd_idx_in;
      end
   end

   // item payload and result buffer
   always_ff @(posedge clock) begin
      bits_ff   <= bits_in;
      rem_ff    <= rem_in;
      decode_ff <= decode_in;
      eos_ff    <= eos_in;
      if (emit && res_n_ff != 2'd2) begin
         res_ff[res_n_ff[0]] <= emit_byte;
      end
   end

   // pending code stays shorter than the longest code
   assert property (@(posedge clock) disable iff (reset) cnt_ff < LEN_W'(CODE_W))
      else $error("pending bit count out of range");

   // a result is only offered from a filled buffer slot
   assert property (@(posedge clock) disable iff (reset)
                    rsp_tvalid |-> ({1'b0, rd_idx_ff} < res_n_ff))
      else $error("result offered from empty slot");

   // end of stream leaves no bits behind
   assert property (@(posedge clock) disable iff (reset)
                    (state_ff == ST_FINISH && eos_ff && !clear) |=> (cnt_ff == '0))
      else $error("bits left after end of stream");

endmodule
